>>> rtl/core/lhist_pkg.sv
`default_nettype none

package lhist_pkg;

    localparam int LEN_W        = 8;
    localparam int CNT_W        = 64;
    localparam int MIN_LENGTH   = 2;
    localparam int DEF_NUM_BINS = 256;
    localparam int MAX_DEPTH    = 1 << LEN_W;

    typedef enum logic [1:0] {
        OP_ADD        = 2'd0,
        OP_READ_BIN   = 2'd1,
        OP_READ_TOTAL = 2'd2,
        OP_CLEAR      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_LENGTH = 2'd1,
        ST_BIN_OVF    = 2'd2,
        ST_TOTAL_OVF  = 2'd3
    } status_t;

    typedef struct packed {
        op_t              op;
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] amount;
    } item_t;

    typedef struct packed {
        logic             en;
        logic [LEN_W-1:0] idx;
    } rd_req_t;

    typedef struct packed {
        logic             en;
        logic [LEN_W-1:0] idx;
        logic [CNT_W-1:0] data;
    } wr_req_t;

endpackage

`default_nettype wire

>>> rtl/core/lhist_in_if.sv
`default_nettype none

interface lhist_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  op;
    logic [lhist_pkg::LEN_W-1:0] length;
    logic [lhist_pkg::CNT_W-1:0] amount;

    modport source (output valid, output op, output length, output amount, input ready);
    modport sink   (input valid, input op, input length, input amount, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lhist_out_if.sv
`default_nettype none

interface lhist_out_if;
    logic                        valid;
    logic                        ready;
    logic [lhist_pkg::CNT_W-1:0] value;
    logic [1:0]                  status;
    logic                        is_empty;

    modport source (output valid, output value, output status, output is_empty, input ready);
    modport sink   (input valid, input value, input status, input is_empty, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lhist_store.sv
`default_nettype none

module lhist_store #(
    parameter int NUM_BINS = lhist_pkg::DEF_NUM_BINS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire lhist_pkg::rd_req_t          rd,
    input  wire lhist_pkg::wr_req_t          wr,
    output logic [lhist_pkg::CNT_W-1:0]      rd_count
);
    import lhist_pkg::*;

    localparam int DEPTH = (NUM_BINS < MAX_DEPTH) ? NUM_BINS : MAX_DEPTH;
    localparam int IDX_W = $clog2(DEPTH);

    logic [CNT_W-1:0] mem [DEPTH];
    logic [CNT_W-1:0] rd_data_reg;
    logic [CNT_W-1:0] fwd_data_reg;
    logic             fwd_hit_reg;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;

    assign rd_idx = rd.idx[IDX_W-1:0];
    assign wr_idx = wr.idx[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_idx] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg  <= mem[rd_idx];
            fwd_data_reg <= wr.data;
        end
    end

    // write landing on the same edge as the read wins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd.en)
        begin
            fwd_hit_reg <= wr.en && (wr_idx == rd_idx);
        end
    end

    assign rd_count = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/lhist_update.sv
`default_nettype none

module lhist_update #(
    parameter int NUM_BINS = lhist_pkg::DEF_NUM_BINS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        fire,
    input  wire lhist_pkg::item_t            item,
    input  wire logic [lhist_pkg::CNT_W-1:0] cur_count,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output logic [lhist_pkg::CNT_W-1:0]      value,
    output logic [1:0]                       status,
    output logic                             is_empty,
    output lhist_pkg::wr_req_t               wr
);
    import lhist_pkg::*;

    localparam int DEPTH = (NUM_BINS < MAX_DEPTH) ? NUM_BINS : MAX_DEPTH;
    localparam int IDX_W = $clog2(DEPTH);

    logic [DEPTH-1:0] present_reg;
    logic [DEPTH-1:0] present_next;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] total_next;
    logic             flag_reg;
    logic             flag_next;
    logic             out_valid_reg;
    logic [CNT_W-1:0] value_reg;
    logic [CNT_W-1:0] value_next;
    status_t          status_reg;
    status_t          status_next;
    logic             empty_reg;

    logic [IDX_W-1:0] idx;
    logic             len_ok;
    logic [CNT_W-1:0] cur;
    logic [CNT_W:0]   bin_sum;
    logic [CNT_W:0]   tot_sum;

    assign idx     = item.len[IDX_W-1:0];
    assign len_ok  = (item.len >= LEN_W'(MIN_LENGTH)) && (32'(item.len) < NUM_BINS);
    assign cur     = (len_ok && present_reg[idx]) ? cur_count : '0;
    assign bin_sum = {1'b0, cur} + {1'b0, item.amount};
    assign tot_sum = {1'b0, total_reg} + {1'b0, item.amount};

    always_comb
    begin
        present_next = present_reg;
        total_next   = total_reg;
        flag_next    = flag_reg;
        value_next   = '0;
        status_next  = ST_OK;
        wr.en        = 1'b0;
        wr.idx       = item.len;
        wr.data      = bin_sum[CNT_W-1:0];
        case (item.op)
            OP_ADD:
            begin
                if (!len_ok)
                begin
                    status_next = ST_BAD_LENGTH;
                end
                else if (item.amount != '0)
                begin
                    if (bin_sum[CNT_W])
                    begin
                        status_next = ST_BIN_OVF;
                    end
                    else
                    begin
                        wr.en             = fire;
                        present_next[idx] = 1'b1;
                        total_next        = tot_sum[CNT_W-1:0];
                        flag_next         = flag_reg | tot_sum[CNT_W];
                    end
                end
            end
            OP_READ_BIN:
            begin
                if (!len_ok)
                begin
                    status_next = ST_BAD_LENGTH;
                end
                else
                begin
                    value_next = cur;
                end
            end
            OP_READ_TOTAL:
            begin
                if (flag_reg)
                begin
                    status_next = ST_TOTAL_OVF;
                end
                else
                begin
                    value_next = total_reg;
                end
            end
            OP_CLEAR:
            begin
                present_next = '0;
                total_next   = '0;
                flag_next    = 1'b0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg   <= '0;
            total_reg     <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            present_reg   <= present_next;
            total_reg     <= total_next;
            flag_reg      <= flag_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
            empty_reg  <= (total_next == '0) && !flag_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;
    assign is_empty  = empty_reg;

endmodule

`default_nettype wire

>>> rtl/core/length_histogram_with_overflow_check_unit.sv
// an accepted beat sits in the input register until the result register can take it
// one beat per cycle unless output stalls, bin read-modify-write forwarded in count memory
// output stall holds the result register and backs up into the input register
// reset clears present marks, running total, overflow flag and valid state at once
// the bin count memory is not cleared; present marks gate every read of it
`default_nettype none

module length_histogram_with_overflow_check_unit #(
    parameter int NUM_BINS = lhist_pkg::DEF_NUM_BINS
) (
    input wire logic  clk,
    input wire logic  rst_n,
    lhist_in_if.sink  in,
    lhist_out_if.source out
);
    import lhist_pkg::*;

    logic    s1_valid_reg;
    item_t   s1_item_reg;
    logic    fire;
    logic    out_valid;
    rd_req_t rd;
    wr_req_t wr;
    logic [CNT_W-1:0] cur_count;

    assign fire     = s1_valid_reg && (!out_valid || out.ready);
    assign in.ready = !s1_valid_reg || fire;
    assign rd.en    = in.valid && in.ready;
    assign rd.idx   = in.length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in.ready)
        begin
            s1_valid_reg <= in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            s1_item_reg.op     <= op_t'(in.op);
            s1_item_reg.len    <= in.length;
            s1_item_reg.amount <= in.amount;
        end
    end

    lhist_store #(
        .NUM_BINS (NUM_BINS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (rd),
        .wr       (wr),
        .rd_count (cur_count)
    );

    lhist_update #(
        .NUM_BINS (NUM_BINS)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (s1_item_reg),
        .cur_count (cur_count),
        .out_ready (out.ready),
        .out_valid (out_valid),
        .value     (out.value),
        .status    (out.status),
        .is_empty  (out.is_empty),
        .wr        (wr)
    );

    assign out.valid = out_valid;

endmodule

`default_nettype wire

>>> rtl/core/lhist_checker.sv
`default_nettype none

module lhist_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [lhist_pkg::CNT_W-1:0] value,
    input wire logic [1:0]                  status,
    input wire logic                        is_empty
);
    import lhist_pkg::*;

    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result beat during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status)
            && $stable(is_empty))
        else $error("stalled result beat changed");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> value == '0)
        else $error("error status with nonzero value");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> value == '0)
        else $error("empty histogram returned nonzero value");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output register free");

endmodule

bind length_histogram_with_overflow_check_unit lhist_checker u_lhist_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .value     (out.value),
    .status    (out.status),
    .is_empty  (out.is_empty)
);

`default_nettype wire
